// ===== rtl/core/ndd_pkg.sv =====
// shared types, constants and helpers for the newton divided-difference core
package ndd_pkg;

  localparam int MaxNodesDefault = 16;
  localparam int FracBitsDefault = 16;
  localparam int DataW           = 32;
  localparam int StatusW         = 3;

  localparam logic [StatusW-1:0] StOk       = 3'd0;
  localparam logic [StatusW-1:0] StNoNodes  = 3'd1;
  localparam logic [StatusW-1:0] StRepeated = 3'd2;
  localparam logic [StatusW-1:0] StSat      = 3'd3;
  localparam logic [StatusW-1:0] StDropped  = 3'd4;

  typedef struct packed {
    logic               mode;
    logic               first_point;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] query_x;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clear_set;
    logic latch_item;
    logic cmp_step;
    logic ld_init;
    logic div_start;
    logic div_finish;
    logic ld_commit;
    logic ev_init;
    logic ev_mul;
    logic ev_add;
    logic ev_done;
    logic mark_repeat;
    logic mark_drop;
  } ndd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mode;
    logic full;
    logic empty;
    logic cmp_match;
    logic cmp_last;
    logic ld_last;
    logic div_busy;
    logic ev_last;
  } ndd_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v, output logic s);
    s = 1'b0;
    if (v > 66'sd2147483647) begin
      s = 1'b1;
      sat32 = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      s = 1'b1;
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ===== rtl/core/newton_divided_difference_interp_core.sv =====
// top level of the newton divided-difference interpolation core
// load: one serial divide per node already stored (49-step serial divider)
// evaluate: one multiply then one add per step
// one item at a time; evaluate result strobed in the same cycle that busy falls
// synchronous active-high reset clears the set and its status flags
module newton_divided_difference_interp_core import ndd_pkg::*; #(
  parameter int MaxNodes = MaxNodesDefault,
  parameter int FracBits = FracBitsDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      result_valid,
  output out_item_t result
);
  ndd_cmd_t  cmd;
  ndd_stat_t stat;
  logic      busy_r, done;

  ndd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start && !busy), .first_point(in_item.first_point),
    .mode(in_item.mode), .stat(stat), .cmd(cmd), .busy(busy_r), .done(done)
  );

  ndd_datapath #(.MaxNodes(MaxNodes), .FracBits(FracBits)) u_dp (
    .clk(clk), .rst(rst), .item(in_item), .cmd(cmd), .stat(stat), .result(result)
  );

  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= done;
  end

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !$past(start && !busy)) else $error("result after accept");
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("double strobe");
endmodule

// ===== rtl/core/ndd_div.sv =====
// serial signed divider, one quotient bit per cycle, truncating toward zero
module ndd_div import ndd_pkg::*; #(
  parameter int NumW = 64,
  parameter int DenW = 33
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [NumW-1:0] num,
  input  logic signed [DenW-1:0] den,
  output logic                   busy,
  output logic signed [NumW-1:0] quo
);
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q;
  logic [NumW-1:0] rem;
  logic [DenW-1:0] dmag;
  logic            neg;
  logic [CntW-1:0] cnt;
  logic [NumW:0]   trial;
  logic [NumW:0]   shifted;

  assign shifted = {rem, q[NumW-1]};
  assign trial   = shifted - {{(NumW+1-DenW){1'b0}}, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CntW'(NumW);
      q    <= num[NumW-1] ? NumW'(-num) : NumW'(num);
      dmag <= den[DenW-1] ? DenW'(-den) : DenW'(den);
      neg  <= num[NumW-1] ^ den[DenW-1];
      rem  <= '0;
    end else if (busy) begin
      if (!trial[NumW]) begin
        rem <= trial[NumW-1:0];
        q   <= {q[NumW-2:0], 1'b1};
      end else begin
        rem <= shifted[NumW-1:0];
        q   <= {q[NumW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntW'(1)) busy <= 1'b0;
    end
  end

  assign quo = neg ? -$signed(q) : $signed(q);
endmodule

// ===== rtl/core/ndd_datapath.sv =====
// node stores, divided-difference update and horner evaluation datapath
module ndd_datapath import ndd_pkg::*; #(
  parameter int MaxNodes = MaxNodesDefault,
  parameter int FracBits = FracBitsDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  item,
  input  ndd_cmd_t  cmd,
  output ndd_stat_t stat,
  output out_item_t result
);
  localparam int IdxW = $clog2(MaxNodes);
  localparam int CntW = $clog2(MaxNodes + 1);
  localparam int NumW = 32 + FracBits + 1;

  logic signed [31:0] xs   [MaxNodes];
  logic signed [31:0] diag [MaxNodes];
  logic signed [31:0] coef [MaxNodes];

  in_item_t           it;
  logic [CntW-1:0]    count;
  logic               rep_flag, sat_flag, drop_flag;
  logic [CntW-1:0]    j;
  logic signed [31:0] cur, old_prev;
  logic               ld_sat, ev_sat;
  logic signed [31:0] r;
  logic signed [65:0] prod;
  logic signed [31:0] xrd, crd;

  logic signed [NumW-1:0] dnum;
  logic signed [32:0]     dden;
  logic                   dbusy;
  logic signed [NumW-1:0] dquo;
  logic [IdxW-1:0]        ci;

  ndd_div #(.NumW(NumW), .DenW(33)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(dnum), .den(dden),
    .busy(dbusy), .quo(dquo)
  );

  logic [CntW-1:0] nm1;
  assign nm1 = count - 1'b1;

  logic               dsat, qsat, asat;
  logic signed [31:0] diff, qv, av;
  always_comb begin
    diff = sat32(66'(cur) - 66'(old_prev), dsat);
    qv   = sat32(66'(dquo), qsat);
    av   = sat32((prod >>> FracBits) + 66'(crd), asat);
  end

  assign dnum = NumW'(diff) <<< FracBits;
  assign dden = 33'(it.node_x) - 33'(xrd);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rep_flag  <= 1'b0;
      sat_flag  <= 1'b0;
      drop_flag <= 1'b0;
    end else begin
      if (cmd.latch_item) it <= item;
      if (cmd.clear_set) begin
        count <= '0; rep_flag <= 1'b0; sat_flag <= 1'b0; drop_flag <= 1'b0;
      end
      if (cmd.mark_repeat) rep_flag <= 1'b1;
      if (cmd.mark_drop)   drop_flag <= 1'b1;
      if (cmd.ld_init) begin
        cur      <= it.node_y;
        old_prev <= diag[0];
        diag[0]  <= it.node_y;
        j        <= CntW'(1);
        ld_sat   <= 1'b0;
      end
      if (cmd.cmp_step) j <= j + 1'b1;
      if (cmd.latch_item) j <= '0;
      if (cmd.div_start) begin
        ld_sat <= ld_sat | dsat;
        old_prev <= (j < count) ? diag[j[IdxW-1:0]] : 32'sd0;
      end
      if (cmd.div_finish) begin
        cur <= qv;
        diag[j[IdxW-1:0]] <= qv;
        ld_sat <= ld_sat | qsat;
        j <= j + 1'b1;
      end
      if (cmd.ld_commit) begin
        xs[count[IdxW-1:0]]   <= it.node_x;
        coef[count[IdxW-1:0]] <= cur;
        count <= count + 1'b1;
        if (ld_sat) sat_flag <= 1'b1;
      end
      if (cmd.ev_init) begin
        r      <= coef[nm1[IdxW-1:0]];
        j      <= nm1;
        ev_sat <= 1'b0;
      end
      if (cmd.ev_mul) prod <= 66'(r) * (66'(it.query_x) - 66'(xrd));
      if (cmd.ev_add) begin
        r <= av;
        ev_sat <= ev_sat | asat;
      end
      if (cmd.ev_mul) j <= j - 1'b1;
      if (cmd.ev_done) begin
        result.value <= (count == '0) ? 32'sd0 : r;
        if (count == '0)          result.status <= StNoNodes;
        else if (rep_flag)        result.status <= StRepeated;
        else if (drop_flag)       result.status <= StDropped;
        else if (sat_flag || ev_sat) result.status <= StSat;
        else                      result.status <= StOk;
      end
    end
  end

  always_comb begin
    if (cmd.ev_mul || cmd.ev_add) ci = IdxW'(j - 1'b1);
    else if (cmd.div_start)       ci = IdxW'(count - j);
    else                          ci = j[IdxW-1:0];
    xrd = xs[ci];
    crd = coef[j[IdxW-1:0]];
  end

  assign stat.mode      = it.mode;
  assign stat.full      = (count == CntW'(MaxNodes));
  assign stat.empty     = (count == '0);
  assign stat.cmp_match = (j < count) && (xs[j[IdxW-1:0]] == it.node_x);
  assign stat.cmp_last  = (j >= count);
  assign stat.ld_last   = (j > count);
  assign stat.div_busy  = dbusy;
  assign stat.ev_last   = (j == '0);
endmodule

// ===== rtl/core/ndd_ctrl.sv =====
// controller state machine for load and evaluate sequencing
module ndd_ctrl import ndd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      first_point,
  input  logic      mode,
  input  ndd_stat_t stat,
  output ndd_cmd_t  cmd,
  output logic      busy,
  output logic      done
);
  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CHECK  = 10'b0000000010,
    S_CMP    = 10'b0000000100,
    S_INIT   = 10'b0000001000,
    S_DSTART = 10'b0000010000,
    S_DWAIT  = 10'b0000100000,
    S_EINIT  = 10'b0001000000,
    S_EMUL   = 10'b0010000000,
    S_EADD   = 10'b0100000000,
    S_EOUT   = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   wait1;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (start) begin
        cmd.latch_item = 1'b1;
        cmd.clear_set  = !mode && first_point;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.mode) state_next = S_EINIT;
        else if (stat.full) begin
          cmd.mark_drop = 1'b1; state_next = S_IDLE;
        end else state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.cmp_last) state_next = S_INIT;
        else if (stat.cmp_match) begin
          cmd.mark_repeat = 1'b1; state_next = S_IDLE;
        end else cmd.cmp_step = 1'b1;
      end
      S_INIT: begin
        cmd.ld_init = 1'b1; state_next = S_DSTART;
      end
      S_DSTART: begin
        if (stat.ld_last) begin
          cmd.ld_commit = 1'b1; state_next = S_IDLE;
        end else begin
          cmd.div_start = 1'b1; state_next = S_DWAIT;
        end
      end
      S_DWAIT: if (!stat.div_busy && wait1) begin
        cmd.div_finish = 1'b1; state_next = S_DSTART;
      end
      S_EINIT: begin
        if (stat.empty) state_next = S_EOUT;
        else begin
          cmd.ev_init = 1'b1; state_next = S_EMUL;
        end
      end
      S_EMUL: begin
        if (stat.ev_last) state_next = S_EOUT;
        else begin
          cmd.ev_mul = 1'b1; state_next = S_EADD;
        end
      end
      S_EADD: begin
        cmd.ev_add = 1'b1; state_next = S_EMUL;
      end
      S_EOUT: begin
        cmd.ev_done = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wait1 <= 1'b0;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      wait1 <= (state == S_DWAIT);
      busy  <= (state_next != S_IDLE);
    end
  end
  assign done = (state == S_EOUT);
endmodule
